// ----- sv/sdcd_pkg.sv -----
// shared constants, types and tables for the serial day to calendar converter
`default_nettype none

package sdcd_pkg;

	// pipeline depth, one register stage per entry
	localparam int NUM_STAGES = 9;

	// field widths
	localparam int SERIAL_W = 22;
	localparam int FRAC_W   = 32;
	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;

	// serial of the fake leap day, 29 feb 1900
	localparam logic [SERIAL_W-1:0] LEAP_SERIAL = 22'd60;
	localparam logic [4:0]          LEAP_DAY    = 5'd29;
	localparam logic [3:0]          LEAP_MONTH  = 4'd2;
	localparam logic [13:0]         LEAP_YEAR   = 14'd1900;

	// 68569 plus the julian day offset 2415019
	localparam logic [22:0] JD_BIAS = 23'd2483588;

	// 400-year cycle: 4*l / 146097, reciprocal floor(2^25/146097) folded with the 4
	localparam logic [17:0] CYC_DAYS  = 18'd146097;
	localparam logic [9:0]  CYC_RECIP = 10'd916;

	// year in cycle: 4000*(l+1) / 1461001, reciprocal floor(2^28/1461001) times 4000
	localparam logic [20:0] YR_DIV    = 21'd1461001;
	localparam logic [19:0] YR_RECIP  = 20'd732000;
	localparam logic [11:0] YR_SCALE  = 12'd4000;
	localparam logic [10:0] YR_DAYS4  = 11'd1461;
	localparam logic [4:0]  DAY_SHIFT = 5'd31;

	// month index: 80*l / 2447, reciprocal floor(2^16/2447) times 80
	localparam logic [11:0] MON_DIV   = 12'd2447;
	localparam logic [11:0] MON_RECIP = 12'd2080;
	localparam logic [6:0]  MON_SCALE = 7'd80;

	// year assembly
	localparam logic [6:0]  CENT_MUL  = 7'd100;
	localparam logic [12:0] CENT_BIAS = 13'd4900;
	localparam logic [3:0]  MON_WRAP  = 4'd11;

	// time split factors
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;
	localparam logic [5:0] SIXTY         = 6'd60;

	// floor(2447*j/80): day count before month index j
	localparam logic [8:0] DAY_BASE [16] = '{
		9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
	};

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} tod_t;

endpackage

`default_nettype wire

// ----- sv/serial_day_to_calendar_datetime.sv -----
// top level: serial day and day fraction stream in, calendar date and time stream out
`default_nettype none

// Converts a spreadsheet serial day (1 = 1 Jan 1900) and a Q0.32 fraction of a
// day into the Gregorian day, month and year and the hour, minute and second.
// Serial 60 gives the historic 29 Feb 1900 and serials below 60 are moved up by
// one day. The block is a nine-stage pipeline: one word enters per clock while
// the output is not stalled. The stage count is set by the date path: one input
// stage for the leap day check and the epoch bias, then each constant division
// as a reciprocal multiply in one stage and a remainder check in the next, for
// three such divisions, with the day-in-year stage between the second and the
// third and a final assembly stage last. The time split takes three multiply
// stages and is delayed to match. Back-pressure on the output ripples through
// per-stage ready so that bubbles are squeezed out.

module serial_day_to_calendar_datetime (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// serial_day [21:0], day_fraction [53:22], zero pad [55:54]
	input  wire logic [55:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// day_of_month [4:0], month_number [8:5], year_number [22:9],
	// hour_of_day [27:23], minute_of_hour [33:28], second_of_minute [39:34]
	output logic [39:0]      m_tdata
);

	logic [sdcd_pkg::NUM_STAGES-1:0] en;
	sdcd_pkg::date_t                 date;
	sdcd_pkg::tod_t                  tod;

	// stage control
	sdcd_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.en        (en)
	);

	// date conversion
	sdcd_date_path u_date (
		.clk        (clk),
		.en         (en),
		.serial_day (s_tdata[21:0]),
		.date       (date)
	);

	// time of day split
	sdcd_time_path u_time (
		.clk          (clk),
		.en           (en),
		.day_fraction (s_tdata[53:22]),
		.tod          (tod)
	);

	// output word packing
	assign m_tdata = {tod.second, tod.minute, tod.hour, date.year, date.month, date.day};

	// every result has a month from 1 to 12 and a nonzero day
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (date.month >= 4'd1) && (date.month <= 4'd12) && (date.day != 5'd0))
		else $error("date out of range");

	// time fields stay inside their clock range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (tod.hour <= 5'd23) && (tod.minute <= 6'd59) && (tod.second <= 6'd59))
		else $error("time of day out of range");

	// a free output never holds back the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is free");

endmodule

`default_nettype wire

// ----- sv/sdcd_pipe_ctl.sv -----
// stage valid bits and per-stage load enables with back-pressure
`default_nettype none

module sdcd_pipe_ctl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [sdcd_pkg::NUM_STAGES-1:0]     en
);

	logic [sdcd_pkg::NUM_STAGES-1:0] valid_q;
	logic [sdcd_pkg::NUM_STAGES:0]   ready;

	// a stage loads when empty or when its content moves on
	always_comb begin
		ready[sdcd_pkg::NUM_STAGES] = out_ready;
		for (int k = sdcd_pkg::NUM_STAGES - 1; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	assign en        = ready[sdcd_pkg::NUM_STAGES-1:0];
	assign in_ready  = ready[0];
	assign out_valid = valid_q[sdcd_pkg::NUM_STAGES-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < sdcd_pkg::NUM_STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/sdcd_date_path.sv -----
// date datapath: serial day to day, month and year over nine stages
`default_nettype none

module sdcd_date_path (
	input  wire logic                                 clk,
	input  wire logic [sdcd_pkg::NUM_STAGES-1:0]      en,
	input  wire logic [sdcd_pkg::SERIAL_W-1:0]        serial_day,
	output sdcd_pkg::date_t                           date
);

	// stage 1: leap day detect, early shift, julian bias
	logic                             leap_in;
	logic [sdcd_pkg::SERIAL_W-1:0]    serial_adj;
	logic [22:0]                      l0_in;
	logic [22:0]                      l0_s1;
	logic                             leap_s1;

	always_comb begin
		leap_in    = serial_day == sdcd_pkg::LEAP_SERIAL;
		serial_adj = (serial_day < sdcd_pkg::LEAP_SERIAL) ? serial_day + 22'd1 : serial_day;
		l0_in      = {1'b0, serial_adj} + sdcd_pkg::JD_BIAS;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			l0_s1   <= l0_in;
			leap_s1 <= leap_in;
		end
	end

	// stage 2: cycle count estimate, may be one low
	logic [32:0] n_prod;
	logic [7:0]  qn_s2;
	logic [22:0] l0_s2;
	logic        leap_s2;

	assign n_prod = 33'(l0_s1) * 33'(sdcd_pkg::CYC_RECIP);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			qn_s2   <= n_prod[32:25];
			l0_s2   <= l0_s1;
			leap_s2 <= leap_s1;
		end
	end

	// stage 3: remainder check fixes the cycle count, day in cycle from remainder
	logic [24:0] x4;
	logic [24:0] n_back;
	logic [24:0] rn;
	logic        n_fix;
	logic [24:0] r1;
	logic [7:0]  n_s3;
	logic [15:0] l1_s3;
	logic        leap_s3;

	always_comb begin
		x4     = {l0_s2, 2'b00};
		n_back = 25'(qn_s2) * 25'(sdcd_pkg::CYC_DAYS);
		rn     = x4 - n_back;
		n_fix  = rn >= 25'(sdcd_pkg::CYC_DAYS);
		r1     = n_fix ? rn - 25'(sdcd_pkg::CYC_DAYS) : rn;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			n_s3    <= qn_s2 + 8'(n_fix);
			l1_s3   <= r1[17:2];
			leap_s3 <= leap_s2;
		end
	end

	// stage 4: year in cycle estimate
	logic [16:0] l1p_s3;
	logic [35:0] i_prod;
	logic [6:0]  qi_s4;
	logic [15:0] l1_s4;
	logic [7:0]  n_s4;
	logic        leap_s4;

	assign l1p_s3 = 17'(l1_s3) + 17'd1;
	assign i_prod = 36'(l1p_s3) * 36'(sdcd_pkg::YR_RECIP);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			qi_s4   <= i_prod[34:28];
			l1_s4   <= l1_s3;
			n_s4    <= n_s3;
			leap_s4 <= leap_s3;
		end
	end

	// stage 5: remainder check fixes the year in cycle
	logic [16:0] l1p_s4;
	logic [27:0] xi;
	logic [27:0] i_back;
	logic [27:0] ri;
	logic [6:0]  i_s5;
	logic [15:0] l1_s5;
	logic [7:0]  n_s5;
	logic        leap_s5;

	always_comb begin
		l1p_s4 = 17'(l1_s4) + 17'd1;
		xi     = 28'(l1p_s4) * 28'(sdcd_pkg::YR_SCALE);
		i_back = 28'(qi_s4) * 28'(sdcd_pkg::YR_DIV);
		ri     = xi - i_back;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			i_s5    <= qi_s4 + 7'(ri >= 28'(sdcd_pkg::YR_DIV));
			l1_s5   <= l1_s4;
			n_s5    <= n_s4;
			leap_s5 <= leap_s4;
		end
	end

	// stage 6: day in year, shifted to a march start
	logic [17:0] yr_days;
	logic [16:0] l2_full;
	logic [8:0]  l2_s6;
	logic [6:0]  i_s6;
	logic [7:0]  n_s6;
	logic        leap_s6;

	always_comb begin
		yr_days = 18'(i_s5) * 18'(sdcd_pkg::YR_DAYS4);
		l2_full = 17'(l1_s5) - 17'(yr_days[17:2]) + 17'(sdcd_pkg::DAY_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			l2_s6   <= l2_full[8:0];
			i_s6    <= i_s5;
			n_s6    <= n_s5;
			leap_s6 <= leap_s5;
		end
	end

	// stage 7: month index estimate
	logic [20:0] j_prod;
	logic [4:0]  qj_s7;
	logic [8:0]  l2_s7;
	logic [6:0]  i_s7;
	logic [7:0]  n_s7;
	logic        leap_s7;

	assign j_prod = 21'(l2_s6) * 21'(sdcd_pkg::MON_RECIP);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			qj_s7   <= j_prod[20:16];
			l2_s7   <= l2_s6;
			i_s7    <= i_s6;
			n_s7    <= n_s6;
			leap_s7 <= leap_s6;
		end
	end

	// stage 8: remainder check fixes the month index
	logic [15:0] xj;
	logic [15:0] j_back;
	logic [15:0] rj;
	logic [4:0]  j_full;
	logic [3:0]  j_s8;
	logic [8:0]  l2_s8;
	logic [6:0]  i_s8;
	logic [7:0]  n_s8;
	logic        leap_s8;

	always_comb begin
		xj     = 16'(l2_s7) * 16'(sdcd_pkg::MON_SCALE);
		j_back = 16'(qj_s7) * 16'(sdcd_pkg::MON_DIV);
		rj     = xj - j_back;
		j_full = qj_s7 + 5'(rj >= 16'(sdcd_pkg::MON_DIV));
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			j_s8    <= j_full[3:0];
			l2_s8   <= l2_s7;
			i_s8    <= i_s7;
			n_s8    <= n_s7;
			leap_s8 <= leap_s7;
		end
	end

	// stage 9: day, month and year, with the fake leap day override
	logic            wrap;
	logic [8:0]      day_full;
	logic [3:0]      month_full;
	logic [15:0]     year_full;
	sdcd_pkg::date_t date_s9;

	always_comb begin
		wrap       = j_s8 >= sdcd_pkg::MON_WRAP;
		day_full   = l2_s8 - sdcd_pkg::DAY_BASE[j_s8];
		month_full = j_s8 + 4'd2 - (wrap ? 4'd12 : 4'd0);
		year_full  = 16'(n_s8) * 16'(sdcd_pkg::CENT_MUL) - 16'(sdcd_pkg::CENT_BIAS)
			+ 16'(i_s8) + 16'(wrap);
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			if (leap_s8) begin
				date_s9.day   <= sdcd_pkg::LEAP_DAY;
				date_s9.month <= sdcd_pkg::LEAP_MONTH;
				date_s9.year  <= sdcd_pkg::LEAP_YEAR;
			end else begin
				date_s9.day   <= day_full[4:0];
				date_s9.month <= month_full;
				date_s9.year  <= year_full[13:0];
			end
		end
	end

	assign date = date_s9;

endmodule

`default_nettype wire

// ----- sv/sdcd_time_path.sv -----
// time datapath: fixed-point split of the day fraction into hour, minute, second
`default_nettype none

module sdcd_time_path (
	input  wire logic                               clk,
	input  wire logic [sdcd_pkg::NUM_STAGES-1:0]    en,
	input  wire logic [sdcd_pkg::FRAC_W-1:0]        day_fraction,
	output sdcd_pkg::tod_t                          tod
);

	// stage 1: hour split
	logic [36:0] h_prod;
	logic [4:0]  hour_s1;
	logic [31:0] r1_s1;

	assign h_prod = 37'(day_fraction) * 37'(sdcd_pkg::HOURS_PER_DAY);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hour_s1 <= h_prod[36:32];
			r1_s1   <= h_prod[31:0];
		end
	end

	// stage 2: minute split
	logic [37:0] m_prod;
	logic [4:0]  hour_s2;
	logic [5:0]  minute_s2;
	logic [31:0] r2_s2;

	assign m_prod = 38'(r1_s1) * 38'(sdcd_pkg::SIXTY);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hour_s2   <= hour_s1;
			minute_s2 <= m_prod[37:32];
			r2_s2     <= m_prod[31:0];
		end
	end

	// stage 3: second split, leftover fraction dropped
	logic [37:0]    s_prod;
	sdcd_pkg::tod_t tod_s3;

	assign s_prod = 38'(r2_s2) * 38'(sdcd_pkg::SIXTY);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			tod_s3.hour   <= hour_s2;
			tod_s3.minute <= minute_s2;
			tod_s3.second <= s_prod[37:32];
		end
	end

	// delay line to line up with the date path
	sdcd_pkg::tod_t tod_dly [sdcd_pkg::NUM_STAGES-3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			tod_dly[0] <= tod_s3;
		end
		for (int k = 1; k < sdcd_pkg::NUM_STAGES - 3; k++) begin
			if (en[k+3]) begin
				tod_dly[k] <= tod_dly[k-1];
			end
		end
	end

	assign tod = tod_dly[sdcd_pkg::NUM_STAGES-4];

endmodule

`default_nettype wire

// ----- bench/datetime_checker.sv -----
`timescale 1ns / 1ps
// checker: predicts the calendar date and time of day of each accepted word and compares results

module datetime_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// serial_day [21:0], day_fraction [53:22], zero pad [55:54]
	input  wire logic [55:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// day_of_month [4:0], month_number [8:5], year_number [22:9],
	// hour_of_day [27:23], minute_of_hour [33:28], second_of_minute [39:34]
	input  wire logic [39:0] m_tdata,
	output int               mismatches,
	output int               outstanding
);

	// julian day of serial zero and the fliegel-van flandern bias
	localparam longint unsigned EPOCH_JDN = 2415019;
	localparam longint unsigned FVF_BIAS  = 68569;

	// laid out so that the packed struct matches the output word bit for bit
	typedef struct packed {
		logic [sdcd_pkg::SEC_W-1:0]   second;
		logic [sdcd_pkg::MIN_W-1:0]   minute;
		logic [sdcd_pkg::HOUR_W-1:0]  hour;
		logic [sdcd_pkg::YEAR_W-1:0]  year;
		logic [sdcd_pkg::MONTH_W-1:0] month;
		logic [sdcd_pkg::DAY_W-1:0]   day;
	} stamp_t;

	stamp_t pending_stamps [$];
	stamp_t got_stamp;
	stamp_t want_stamp;

	// date by the integer julian formula, time by exact fixed-point splits
	function automatic stamp_t predict_stamp(input logic [sdcd_pkg::SERIAL_W-1:0] serial,
			input logic [sdcd_pkg::FRAC_W-1:0] frac);
		bit [63:0] s, l, n, i, j, k, v, p;
		stamp_t r;
		s = 64'(serial);
		if (serial == sdcd_pkg::LEAP_SERIAL) begin
			// historic fake leap day
			r.day   = sdcd_pkg::DAY_W'(29);
			r.month = sdcd_pkg::MONTH_W'(2);
			r.year  = sdcd_pkg::YEAR_W'(1900);
		end else begin
			// early serials sit one day off the real calendar
			if (s < 64'(sdcd_pkg::LEAP_SERIAL))
				s = s + 1;
			l = s + FVF_BIAS + EPOCH_JDN;
			n = (4 * l) / 146097;
			l = l - (146097 * n + 3) / 4;
			i = (4000 * (l + 1)) / 1461001;
			l = l - (1461 * i) / 4 + 31;
			j = (80 * l) / 2447;
			v = l - (2447 * j) / 80;
			r.day = v[sdcd_pkg::DAY_W-1:0];
			k = j / 11;
			v = j + 2 - 12 * k;
			r.month = v[sdcd_pkg::MONTH_W-1:0];
			v = 100 * (n - 49) + i + k;
			r.year = v[sdcd_pkg::YEAR_W-1:0];
		end
		// hour, minute and second each take the integer part of a scaled remainder
		p = 64'(frac) * 24;
		r.hour = p[32 +: sdcd_pkg::HOUR_W];
		p = {32'b0, p[31:0]} * 60;
		r.minute = p[32 +: sdcd_pkg::MIN_W];
		p = {32'b0, p[31:0]} * 60;
		r.second = p[32 +: sdcd_pkg::SEC_W];
		return r;
	endfunction

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// output words are compared against the oldest prediction, input words queue new ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_stamps.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_stamp = stamp_t'(m_tdata);
				if (pending_stamps.size() == 0) begin
					report($sformatf("result word %h with no input word pending", m_tdata));
				end else begin
					want_stamp = pending_stamps.pop_front();
					check_field("day_of_month", int'(got_stamp.day),
						int'(want_stamp.day));
					check_field("month_number", int'(got_stamp.month),
						int'(want_stamp.month));
					check_field("year_number", int'(got_stamp.year),
						int'(want_stamp.year));
					check_field("hour_of_day", int'(got_stamp.hour),
						int'(want_stamp.hour));
					check_field("minute_of_hour", int'(got_stamp.minute),
						int'(want_stamp.minute));
					check_field("second_of_minute", int'(got_stamp.second),
						int'(want_stamp.second));
				end
			end
			if (s_tvalid && s_tready)
				pending_stamps.push_back(predict_stamp(s_tdata[sdcd_pkg::SERIAL_W-1:0],
					s_tdata[sdcd_pkg::SERIAL_W +: sdcd_pkg::FRAC_W]));
			outstanding <= pending_stamps.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus, output stalls and the verdict

module tb_top;

	localparam int RANDOM_WORDS = 830;
	localparam int CALM_WORDS   = 120;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 4 * sdcd_pkg::NUM_STAGES;
	localparam int LAST_SERIAL  = 2958465;
	localparam int EDGE_WORDS   = 18;

	// directed words: field extremes, the fake leap day and its neighbors, leap years,
	// the top of the serial range and beyond it, hour and second boundaries
	localparam logic [sdcd_pkg::SERIAL_W-1:0] EDGE_SERIAL [EDGE_WORDS] = '{
		22'd0,       22'd1,       22'd59,      22'd60,      22'd61,      22'd2,
		22'd366,     22'd367,     22'd36585,   22'd36586,   22'd73110,   22'd2958465,
		22'd2958466, 22'h3FFFFF,  22'h3FFFFF,  22'h2AAAAA,  22'h155555,  22'd45000
	};
	localparam logic [sdcd_pkg::FRAC_W-1:0] EDGE_FRAC [EDGE_WORDS] = '{
		32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h0AAAAAAB, 32'h0AAAAAAA, 32'h00000001,
		32'h002D82D9, 32'hFFFF3DEF, 32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF, 32'hFFFFFFFF,
		32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'h2AAAAAAA, 32'hD5555555, 32'hFFFF3DC8
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// serial_day [21:0], day_fraction [53:22], zero pad [55:54]
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// day_of_month [4:0], month_number [8:5], year_number [22:9],
	// hour_of_day [27:23], minute_of_hour [33:28], second_of_minute [39:34]
	logic [39:0] m_tdata;

	int          mismatches;
	int          outstanding;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;

	serial_day_to_calendar_datetime DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	datetime_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output stalls in random bursts, none in the calm tail
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// present one word and hold it until it is taken
	task automatic send_word(input logic [sdcd_pkg::SERIAL_W-1:0] serial,
			input logic [sdcd_pkg::FRAC_W-1:0] frac);
		s_tdata  <= {2'b00, frac, serial};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// random input gap after a word
	task automatic pace_sender();
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// stop sending until every pending result is out
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin
		logic [sdcd_pkg::SERIAL_W-1:0] serial;
		logic [sdcd_pkg::FRAC_W-1:0]   frac;
		int unsigned                   pick;
		longint unsigned               secs;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words
		for (int w = 0; w < EDGE_WORDS; w++) begin
			send_word(EDGE_SERIAL[w], EDGE_FRAC[w]);
			pace_sender();
		end
		hold_until_drained();

		// random words, mostly in the documented range
		for (int w = 0; w < RANDOM_WORDS; w++) begin
			calm   = (w >= RANDOM_WORDS - CALM_WORDS);
			pick   = $urandom_range(0, 9);
			serial = sdcd_pkg::SERIAL_W'($urandom_range(1, LAST_SERIAL));
			frac   = $urandom;
			if (pick == 0) begin
				// around the fake leap day
				serial = sdcd_pkg::SERIAL_W'($urandom_range(0, 120));
			end else if (pick == 1) begin
				// whole field, beyond the documented range too
				serial = sdcd_pkg::SERIAL_W'($urandom_range(0, 32'h3FFFFF));
			end else if (pick == 2) begin
				// on or just below a second boundary
				secs = 64'($urandom_range(0, 86399));
				frac = 32'(((secs << 32) + 64'd86399) / 64'd86400
					- 64'($urandom_range(0, 1)));
			end
			send_word(serial, frac);
			if (w == 300 || w == 550)
				hold_until_drained();
			else
				pace_sender();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/sdcd_pkg.sv
sv/sdcd_pipe_ctl.sv
sv/sdcd_date_path.sv
sv/sdcd_time_path.sv
sv/serial_day_to_calendar_datetime.sv
bench/datetime_checker.sv
bench/tb_top.sv
